// File: src/lbcbf_pkg.sv
// Shared types and constants for the layered bit counter Bloom filter.
`default_nettype none
package lbcbf_pkg;

    localparam int MAX_BLOCKS_DEF  = 8;
    localparam int MAX_CELLS_DEF   = 1024;
    localparam int LAYERS_DEF      = 3;

    localparam int VALUE_BITS      = 8;
    localparam int MAX_KEY_BYTES   = 256;
    localparam int LEN_W           = 9;
    localparam int BLOCKS_W        = 4;
    localparam int CELLS_W         = 11;
    localparam int CFG_DATA_W      = 11;

    localparam logic [31:0] MIX_MUL = 32'h5bd1e995;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic CFG_ACTIVE_BLOCKS   = 1'b0;
    localparam logic CFG_CELLS_PER_BLOCK = 1'b1;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [31:0]           key_word;
        logic [LEN_W-1:0]      key_length;
        logic                  last;
        logic [VALUE_BITS-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_BITS-1:0] answer;
        logic                  was_query;
    } t_out_item;

    typedef struct packed {
        logic               start;
        logic [31:0]        dividend;
        logic [CELLS_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [CELLS_W-1:0] remainder;
    } t_mod_rsp;

endpackage
`default_nettype wire

// File: src/lbcbf_mul.sv
// Shared 32x32 multiplier, low word of the product, registered.
`default_nettype none
module lbcbf_mul (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [31:0] o_p
);
    logic [63:0] full;
    logic [31:0] r_p;

    assign full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_p <= full[31:0];
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

// File: src/lbcbf_mod.sv
// Restoring remainder unit, one dividend bit per cycle.
`default_nettype none
module lbcbf_mod (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire lbcbf_pkg::t_mod_req i_req,
    output lbcbf_pkg::t_mod_rsp      o_rsp
);
    import lbcbf_pkg::*;

    logic [31:0]        r_q;
    logic [CELLS_W-1:0] r_r;
    logic [CELLS_W-1:0] r_d;
    logic [5:0]         r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [CELLS_W:0]   trial;
    logic [CELLS_W:0]   n_r;

    always_comb begin
        trial = {r_r, r_q[31]};
        n_r   = (trial >= {1'b0, r_d}) ? trial - {1'b0, r_d} : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_q    <= i_req.dividend;
                r_d    <= i_req.divisor;
                r_r    <= '0;
                r_cnt  <= 6'd32;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[30:0], 1'b0};
                r_r   <= n_r[CELLS_W-1:0];
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy      = r_busy;
    assign o_rsp.done      = r_done;
    assign o_rsp.remainder = r_r;
endmodule
`default_nettype wire

// File: src/lbcbf_cell_mem.sv
// Cell layer memory: one write port, one read port with registered data.
`default_nettype none
module lbcbf_cell_mem #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13,
    parameter int MW    = 24
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [MW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [MW-1:0] o_rdata
);
    logic [MW-1:0] r_mem [DEPTH];
    logic [MW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// File: src/layered_bit_counter_bloom_filter.sv
// A key word is mixed into all MAX_BLOCKS block hashes, after a premix if it is whole.
// The last word (opcode not OP_NONE) adds per active block a finishing multiply, a
// remainder, a read and, but for a query, a write. All multiplies share one unit.
// Throughput: one item at a time; input stall is high from acceptance to completion.
// Reset (synchronous, active low) starts a clearing pass of MAX_BLOCKS*MAX_CELLS_PER_BLOCK
// cells (8192 by default) over the cell memory; no item is taken until it ends.
`default_nettype none
module layered_bit_counter_bloom_filter #(
    parameter int MAX_BLOCKS          = lbcbf_pkg::MAX_BLOCKS_DEF,
    parameter int MAX_CELLS_PER_BLOCK = lbcbf_pkg::MAX_CELLS_DEF,
    parameter int LAYERS              = lbcbf_pkg::LAYERS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire lbcbf_pkg::t_in_item                  i_in_item,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output lbcbf_pkg::t_out_item                      o_out_item,
    input  wire logic                                 i_cfg_we,
    input  wire logic                                 i_cfg_index,
    input  wire logic [lbcbf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import lbcbf_pkg::*;

    localparam int DEPTH = MAX_BLOCKS * MAX_CELLS_PER_BLOCK;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int NBW   = $clog2(MAX_BLOCKS + 1);
    localparam int MW    = LAYERS * VALUE_BITS;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_K1, S_K2, S_K3, S_MIX, S_MIXW,
        S_FIN, S_FINW, S_MOD, S_RD, S_RDW, S_DONE
    } t_state;

    typedef enum logic [1:0] {M_NONE, M_FULL, M_TAIL} t_mode;

    t_state                r_state;
    logic [BLOCKS_W-1:0]   r_active;
    logic [CELLS_W-1:0]    r_cells;
    logic [LEN_W-1:0]      r_taken;
    logic [1:0]            r_op;
    logic [31:0]           r_word;
    logic [LEN_W-1:0]      r_len;
    logic                  r_last;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_first;
    t_mode                 r_mode;
    logic [1:0]            r_tail_n;
    logic [31:0]           r_k;
    logic [31:0]           r_acc [MAX_BLOCKS];
    logic [NBW-1:0]        r_b;
    logic [AW-1:0]         r_base;
    logic [CELLS_W-1:0]    r_rem;
    logic [VALUE_BITS-1:0] r_answer;
    logic [AW-1:0]         r_clr;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    // Input side
    logic                  accept_in;
    logic [LEN_W-1:0]      len_sat;
    logic [LEN_W-1:0]      remaining;
    // Configuration clamps
    logic [NBW-1:0]        nblk;
    logic [CELLS_W-1:0]    ncell;
    // Hash datapath
    logic [31:0]           cur_acc;
    logic [31:0]           h0;
    logic [31:0]           tail_bits;
    logic [31:0]           mix_a;
    logic [31:0]           prod;
    logic [31:0]           new_acc;
    logic [31:0]           fin_h;
    t_mod_req              mod_req;
    t_mod_rsp              mod_rsp;
    // Cell update
    logic [AW-1:0]         cell_addr;
    logic [MW-1:0]         rdata;
    logic [MW-1:0]         upd_data;
    logic [VALUE_BITS-1:0] or_layers;
    logic [VALUE_BITS-1:0] carry;
    logic [VALUE_BITS-1:0] lay;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [MW-1:0]         mem_wdata;
    logic                  out_free;

    assign accept_in = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        len_sat   = (int'(i_in_item.key_length) > MAX_KEY_BYTES) ?
                    LEN_W'(MAX_KEY_BYTES) : i_in_item.key_length;
        remaining = (len_sat > r_taken) ? len_sat - r_taken : '0;
        nblk      = (int'(r_active) > MAX_BLOCKS) ? NBW'(MAX_BLOCKS) : NBW'(r_active);
        if (r_cells == '0) begin
            ncell = CELLS_W'(1);
        end else if (int'(r_cells) > MAX_CELLS_PER_BLOCK) begin
            ncell = CELLS_W'(MAX_CELLS_PER_BLOCK);
        end else begin
            ncell = r_cells;
        end
    end

    // Seed on the first word of a key, otherwise the running accumulator.
    always_comb begin
        cur_acc = r_acc[r_b[BW-1:0]];
        h0      = r_first ? (32'(r_b) ^ 32'(r_len)) : cur_acc;
        case (r_tail_n)
            2'd3:    tail_bits = {8'h00, r_word[23:0]};
            2'd2:    tail_bits = {16'h0000, r_word[15:0]};
            2'd1:    tail_bits = {24'h000000, r_word[7:0]};
            default: tail_bits = '0;
        endcase
        case (r_state)
            S_K1:    mix_a = r_word;
            S_K2:    mix_a = prod ^ (prod >> 24);
            S_MIX:   mix_a = (r_mode == M_TAIL) ? (h0 ^ tail_bits) : h0;
            S_FIN:   mix_a = cur_acc ^ (cur_acc >> 13);
            default: mix_a = r_word;
        endcase
        case (r_mode)
            M_FULL:  new_acc = prod ^ r_k;
            M_TAIL:  new_acc = prod;
            default: new_acc = h0;
        endcase
        fin_h = prod ^ (prod >> 15);
    end

    lbcbf_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mix_a),
        .i_b   (MIX_MUL),
        .o_p   (prod)
    );

    assign mod_req.start    = (r_state == S_FINW);
    assign mod_req.dividend = fin_h;
    assign mod_req.divisor  = ncell;

    lbcbf_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    // Layer update: bit j of the layers is a ripple counter for value bit j.
    always_comb begin
        cell_addr = r_base + AW'(r_rem);
        or_layers = '0;
        carry     = r_value;
        upd_data  = '0;
        for (int l = 0; l < LAYERS; l++) begin
            or_layers = or_layers | rdata[l*VALUE_BITS +: VALUE_BITS];
            lay       = rdata[l*VALUE_BITS +: VALUE_BITS] ^ carry;
            upd_data[l*VALUE_BITS +: VALUE_BITS] = lay;
            carry = (r_op == OP_INSERT) ? (carry & lay) : (carry & ~lay);
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cell_addr;
        mem_wdata = upd_data;
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = '0;
        end else if (r_state == S_RDW && r_op != OP_QUERY) begin
            mem_we = 1'b1;
        end
    end

    lbcbf_cell_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .MW    (MW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (cell_addr),
        .o_rdata (rdata)
    );

    // Output slot is free when empty or being taken this cycle.
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_taken     <= '0;
            r_active    <= BLOCKS_W'(8);
            r_cells     <= CELLS_W'(1024);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ACTIVE_BLOCKS:   r_active <= i_cfg_data[BLOCKS_W-1:0];
                    CFG_CELLS_PER_BLOCK: r_cells  <= i_cfg_data[CELLS_W-1:0];
                    default: ;
                endcase
            end
            // S_DONE loads the slot itself
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr <= r_clr + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (accept_in) begin
                        r_op     <= i_in_item.opcode;
                        r_word   <= i_in_item.key_word;
                        r_len    <= len_sat;
                        r_last   <= i_in_item.last;
                        r_value  <= i_in_item.value;
                        r_first  <= (r_taken == '0);
                        r_tail_n <= remaining[1:0];
                        r_b      <= '0;
                        if (remaining >= LEN_W'(4)) begin
                            r_mode  <= M_FULL;
                            r_state <= S_K1;
                        end else if (remaining != '0) begin
                            r_mode  <= M_TAIL;
                            r_state <= S_MIX;
                        end else begin
                            r_mode  <= M_NONE;
                            r_state <= S_MIX;
                        end
                        if (i_in_item.last) begin
                            r_taken <= '0;
                        end else if (remaining >= LEN_W'(4)) begin
                            r_taken <= r_taken + LEN_W'(4);
                        end else begin
                            r_taken <= r_taken + remaining;
                        end
                    end
                end
                S_K1: r_state <= S_K2;
                S_K2: r_state <= S_K3;
                S_K3: begin
                    r_k     <= prod;
                    r_state <= S_MIX;
                end
                S_MIX: r_state <= S_MIXW;
                S_MIXW: begin
                    r_acc[r_b[BW-1:0]] <= new_acc;
                    if (r_b == NBW'(MAX_BLOCKS - 1)) begin
                        r_b      <= '0;
                        r_base   <= '0;
                        r_answer <= '1;
                        if (!r_last || r_op == OP_NONE) begin
                            r_state <= S_IDLE;
                        end else if (nblk == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end else begin
                        r_b     <= r_b + NBW'(1);
                        r_state <= S_MIX;
                    end
                end
                S_FIN:  r_state <= S_FINW;
                S_FINW: r_state <= S_MOD;
                S_MOD: begin
                    if (mod_rsp.done) begin
                        r_rem   <= mod_rsp.remainder;
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_RDW;
                S_RDW: begin
                    if (r_op == OP_QUERY) begin
                        r_answer <= r_answer & or_layers;
                    end
                    r_base <= r_base + AW'(ncell);
                    r_b    <= r_b + NBW'(1);
                    if (r_b + NBW'(1) == nblk) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid          <= 1'b1;
                        r_out_item.was_query <= (r_op == OP_QUERY);
                        r_out_item.answer    <= (r_op == OP_QUERY) ? r_answer : '0;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
endmodule
`default_nettype wire

// File: src/lbcbf_checker.sv
// Port-level checks for the layered bit counter Bloom filter, bound to the top level.
`default_nettype none
module lbcbf_assert (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_in_valid,
    input wire logic                             o_in_stall,
    input wire lbcbf_pkg::t_in_item              i_in_item,
    input wire logic                             o_out_valid,
    input wire logic                             i_out_stall,
    input wire lbcbf_pkg::t_out_item             o_out_item,
    input wire logic                             i_cfg_we,
    input wire logic                             i_cfg_index,
    input wire logic [lbcbf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lbcbf_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again without processing");

    a_update_answer_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.was_query |-> o_out_item.answer == '0)
        else $error("insert or delete item carries a nonzero answer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output item changed");
endmodule

bind layered_bit_counter_bloom_filter lbcbf_assert u_lbcbf_assert (.*);
`default_nettype wire

// File: dv/lbcbf_checker.sv
// Checker for the layered bit counter Bloom filter: predicts each result and compares it.
`timescale 1ns / 1ps
module lbcbf_checker
    import lbcbf_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_stall,
    input  wire t_in_item  i_in_item,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_stall,
    input  wire t_out_item i_out_item,
    input  wire logic      i_cfg_we,
    input  wire logic      i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int             o_errors,
    output int             o_pending,
    output int             o_results,
    output int             o_queries
);
    localparam int NBLK  = MAX_BLOCKS_DEF;
    localparam int NCELL = MAX_CELLS_DEF;
    localparam int NLAY  = LAYERS_DEF;

    logic [7:0]  layer_mem [0:NBLK*NCELL*NLAY-1];
    logic [31:0] seed_acc [NBLK];
    int unsigned bytes_taken;
    logic [BLOCKS_W-1:0] blocks_reg;
    logic [CELLS_W-1:0]  cells_reg;
    t_out_item   answer_q [$];

    function automatic logic [31:0] mix_full(logic [31:0] h, logic [31:0] k);
        k = k * MIX_MUL;
        k ^= k >> 24;
        k = k * MIX_MUL;
        return (h * MIX_MUL) ^ k;
    endfunction

    function automatic logic [31:0] mix_partial(logic [31:0] h, logic [31:0] w, int unsigned n);
        if (n >= 3) h ^= {8'h0, w[23:16], 16'h0};
        if (n >= 2) h ^= {16'h0, w[15:8], 8'h0};
        if (n >= 1) begin
            h ^= {24'h0, w[7:0]};
            h = h * MIX_MUL;
        end
        return h;
    endfunction

    function automatic logic [31:0] hash_final(logic [31:0] h);
        h ^= h >> 13;
        h = h * MIX_MUL;
        h ^= h >> 15;
        return h;
    endfunction

    // Advance the per-seed hashes by one key word; on the last word run the operation.
    task automatic take_key_word(t_in_item it);
        int unsigned len, remaining, nb, nc, slot, b, l;
        logic [31:0] h;
        logic [7:0]  carry, mask, acc;
        t_out_item   res;
        len = it.key_length;
        if (len > MAX_KEY_BYTES) len = MAX_KEY_BYTES;
        if (bytes_taken == 0)
            for (b = 0; b < NBLK; b++) seed_acc[b] = b ^ len;
        remaining = (len > bytes_taken) ? len - bytes_taken : 0;
        if (remaining >= 4) begin
            for (b = 0; b < NBLK; b++) seed_acc[b] = mix_full(seed_acc[b], it.key_word);
            bytes_taken += 4;
        end else if (remaining > 0) begin
            for (b = 0; b < NBLK; b++)
                seed_acc[b] = mix_partial(seed_acc[b], it.key_word, remaining);
            bytes_taken += remaining;
        end
        if (!it.last) return;
        bytes_taken = 0;
        if (it.opcode == OP_NONE) return;
        nb = (blocks_reg > NBLK) ? NBLK : blocks_reg;
        nc = (cells_reg == 0) ? 1 : ((cells_reg > NCELL) ? NCELL : cells_reg);
        mask = 8'hFF;
        for (b = 0; b < nb; b++) begin
            h = hash_final(seed_acc[b]);
            slot = (nc * b + h % nc) * NLAY;
            if (it.opcode == OP_QUERY) begin
                acc = 8'h00;
                for (l = 0; l < NLAY; l++) acc |= layer_mem[slot + l];
                mask &= acc;
            end else begin
                carry = it.value;
                for (l = 0; l < NLAY; l++) begin
                    layer_mem[slot + l] ^= carry;
                    if (it.opcode == OP_INSERT) carry &= layer_mem[slot + l];
                    else carry &= ~layer_mem[slot + l];
                end
            end
        end
        res.answer    = (it.opcode == OP_QUERY) ? mask : 8'h00;
        res.was_query = (it.opcode == OP_QUERY);
        answer_q.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < NBLK*NCELL*NLAY; i++) layer_mem[i] = 8'h00;
            bytes_taken = 0;
            blocks_reg  = 4'd8;
            cells_reg   = 11'd1024;
            answer_q.delete();
            o_errors  <= 0;
            o_results <= 0;
            o_queries <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_results <= o_results + 1;
                if (answer_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, %s=%02h query=%0b",
                             $time, "actual answer", i_out_item.answer,
                             i_out_item.was_query);
                    o_errors <= o_errors + 1;
                end else begin
                    want = answer_q.pop_front();
                    if (want.was_query) o_queries <= o_queries + 1;
                    if (want.answer !== i_out_item.answer ||
                        want.was_query !== i_out_item.was_query) begin
                        $display("%0t: mismatch, expected answer=%02h query=%0b, %s=%02h query=%0b",
                                 $time, want.answer, want.was_query, "actual answer",
                                 i_out_item.answer, i_out_item.was_query);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) take_key_word(i_in_item);
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_ACTIVE_BLOCKS) blocks_reg = i_cfg_data[BLOCKS_W-1:0];
                else cells_reg = i_cfg_data[CELLS_W-1:0];
            end
        end
        o_pending <= answer_q.size();
    end

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_results = 0;
        o_queries = 0;
    end
endmodule

// File: dv/testbench.sv
// Top of the testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module testbench;
    import lbcbf_pkg::*;

    localparam int ITEMS_GOAL  = 1150;
    localparam int POOL        = 24;
    localparam int STALL_LIMIT = 40000;   // clearing pass plus slowest item, with margin
    localparam int DRAIN       = 600;     // worst single key op with 8 blocks, rounded up

    logic i_clk;
    logic i_rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    t_in_item  in_item;
    t_out_item out_item;
    logic cfg_we, cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int errors, pending, results, queries;
    int words_sent;
    bit calm;                   // no idling on either side while set

    // key pool: reused keys so queries see earlier inserts
    int unsigned pool_len [POOL];
    logic [31:0] pool_words [POOL][64];

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    layered_bit_counter_bloom_filter u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    lbcbf_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_in_stall (in_stall),
        .i_in_item  (in_item),
        .i_out_valid(out_valid),
        .i_out_stall(out_stall),
        .i_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_results  (results),
        .o_queries  (queries)
    );

    // receiver backpressure
    always @(posedge i_clk) begin
        out_stall <= !calm && ($urandom_range(99) < 31);
    end

    // watchdog: cycles with no item moving on either channel
    always @(posedge i_clk) begin : watchdog
        int quiet;
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
        else quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("%0t: timeout, no item moved for %0d cycles", $time, quiet);
            $display("[layered_bit_counter_bloom_filter] ERROR");
            $finish;
        end
    end

    // one key word; sender may idle first
    task automatic send_word(logic [1:0] op, logic [31:0] w, int unsigned len, bit lst,
                             logic [7:0] v);
        if (!calm && $urandom_range(99) < 31) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{opcode: op, key_word: w, key_length: len[LEN_W-1:0], last: lst, value: v};
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        words_sent++;
    endtask

    // whole key: nwords words, opcode on the last word
    task automatic send_key(logic [1:0] op, int unsigned len, int unsigned nwords,
                            logic [31:0] words [64], logic [7:0] v);
        for (int i = 0; i < nwords; i++)
            send_word(i + 1 == nwords ? op : 2'($urandom), words[i % 64], len,
                      i + 1 == nwords, v);
    endtask

    // every result in, then room for an opcode-3 key still in flight
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic set_config(int unsigned blocks, int unsigned cells);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ACTIVE_BLOCKS;
        cfg_data  <= CFG_DATA_W'(blocks);
        @(posedge i_clk);
        cfg_index <= CFG_CELLS_PER_BLOCK;
        cfg_data  <= CFG_DATA_W'(cells);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [1:0] pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 40) return OP_INSERT;
        if (r < 60) return OP_DELETE;
        if (r < 95) return OP_QUERY;
        return OP_NONE;
    endfunction

    initial begin
        logic [31:0] w [64];
        int unsigned len, nw, k;
        int unsigned phase_blocks [6] = '{1, 0, 15, 3, 8, 2};
        int unsigned phase_cells  [6] = '{1, 9, 2047, 0, 1024, 5};

        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        out_stall = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_ACTIVE_BLOCKS;
        cfg_data  = '0;
        calm      = 1'b0;
        words_sent = 0;

        for (int p = 0; p < POOL; p++) begin
            pool_len[p] = (p == 0) ? 256 : (p < 3 ? $urandom_range(13, 40) : $urandom_range(0, 12));
            for (int i = 0; i < 64; i++) pool_words[p][i] = $urandom;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_config(8, 1024);

        // directed: short keys of every tail size, all-zero and all-one data
        for (int n = 0; n <= 4; n++) begin
            w[0] = (n % 2) ? 32'hFFFF_FFFF : 32'h0;
            send_key(OP_INSERT, n, 1, w, 8'hFF);
            send_key(OP_QUERY,  n, 1, w, 8'h00);
        end
        w[0] = 32'hFFFF_FFFF;
        send_key(OP_DELETE, 1, 1, w, 8'hFF);
        send_key(OP_QUERY,  1, 1, w, 8'h00);
        send_key(OP_NONE,   4, 1, w, 8'hA5);         // unused opcode: no result
        send_key(OP_INSERT, 511, 1, w, 8'h5A);       // length saturates
        send_key(OP_QUERY,  256, 1, w, 8'h00);
        w[1] = 32'h1234_5678;
        send_key(OP_INSERT, 2, 2, w, 8'h3C);         // word after all bytes taken
        send_word(OP_QUERY, 32'hDEAD_BEEF, 8, 1'b0, 8'h00);  // length changes mid-key
        send_word(OP_QUERY, 32'h0BAD_F00D, 5, 1'b1, 8'h00);

        // pause until every result is back before the config changes
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            set_config(phase_blocks[ph], phase_cells[ph]);
            calm = (ph == 4);
            while (words_sent < 25 + (ph + 1) * (ITEMS_GOAL - 25) / 6) begin
                k = $urandom_range(POOL - 1);
                if ($urandom_range(99) < 80) begin
                    len = pool_len[k];
                    w   = pool_words[k];
                end else begin
                    len = ($urandom_range(99) < 5) ? $urandom_range(257, 511) : $urandom_range(0, 20);
                    for (int i = 0; i < 64; i++) w[i] = $urandom;
                end
                nw = (len > 256 ? 256 : len + 3) / 4;
                if (nw == 0) nw = 1;
                if ($urandom_range(99) < 10) nw = $urandom_range(1, nw + 2);   // broken key
                if (nw > 64) nw = 64;
                send_key(pick_op(), len, nw, w, 8'($urandom));
            end
        end
        calm = 1'b0;
        settle();

        $display("Covered %0d key words, %0d results (%0d queries) over 7 configurations.",
                 words_sent, results, queries);
        if (errors == 0) begin
            $display("[layered_bit_counter_bloom_filter] OK");
        end else begin
            $display("[layered_bit_counter_bloom_filter] ERROR");
        end
        $finish;
    end
endmodule
